/* rtl/pec15sfc_pkg.sv */
// Package for the PEC-15 segment frame checker.
// Holds the segment layout constants, register codes and the bytewise PEC update.
// No dependencies.
package pec15sfc_pkg;

  // Segment layout: six data bytes followed by a two-byte PEC, high byte first.
  localparam int unsigned DATA_LEN = 6;
  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_PEC_HIGH = 3'(DATA_LEN);
  localparam logic [POS_W-1:0] POS_PEC_LOW = 3'(DATA_LEN + 1);

  // Segment counting and configuration widths.
  localparam int unsigned SEG_CNT_W = 5;
  localparam int unsigned SEG_IDX_W = 4;
  localparam int unsigned WORD_W = 16;

  // Output stream packing: index and three words, padded to whole bytes.
  localparam int unsigned OUT_USED_W = SEG_IDX_W + 3 * WORD_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_SEGMENTS_IN_USE = 1'b0;

  // CRC-15 parameters.
  localparam logic [15:0] PEC_SEED = 16'h0010;
  localparam logic [15:0] PEC_POLY = 16'h4599;

  typedef logic [7:0] byte_t;

  // One byte of the CRC-15, MSB first; the table entry is worked bit by bit.
  function automatic logic [15:0] pec_update(input logic [15:0] rem, input byte_t b);
    logic [7:0] idx;
    logic [15:0] r;
    idx = rem[14:7] ^ b;
    r = {1'b0, idx, 7'b0};
    for (int k = 0; k < 8; k++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ PEC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return {rem[7:0], 8'h00} ^ r;
  endfunction

endpackage

/* rtl/pec15_segment_frame_checker_unit.sv */
// Top level of the PEC-15 segment frame checker: byte stream in, checked words out.
// Depends on pec15sfc_pkg; one APB-style register sets the chained segment count.
// The result is registered and appears in the cycle after the eighth byte of a segment is accepted.
// Throughput: one byte per cycle; the only limit is the single output register,
// which stalls input while it holds a result that has not been taken.
// Reset (rst, synchronous, active high) empties the output register, clears the
// byte and segment counters, seeds the CRC and sets segments_in_use to 1.
module pec15_segment_frame_checker_unit #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pec15sfc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pec15sfc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pec15sfc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  // Byte input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]                            s_axis_tuser,   // [0] frame_start
  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [3:0] segment_index, [19:4] reg_word0, [35:20] reg_word1, [51:36] reg_word2
  output logic [pec15sfc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [0:0]                            m_axis_tuser,   // [0] status
  output logic                                  m_axis_tlast    // last_segment
);
  import pec15sfc_pkg::*;

  localparam logic [SEG_CNT_W-1:0] MaxSegs = SEG_CNT_W'(MAX_SEGMENTS);

  // Configuration register
  logic [SEG_CNT_W-1:0] segments_in_use;
  logic                 cfg_write;

  // Frame state
  logic [POS_W-1:0]     byte_position, byte_position_next;
  logic [SEG_CNT_W-1:0] segment_count, segment_count_next;
  logic [15:0]          crc_remainder, crc_remainder_next;
  byte_t                data_bytes [DATA_LEN];
  byte_t                pec_high_byte;

  // Per-byte working values
  logic                 in_accept;
  logic [SEG_CNT_W-1:0] segs;
  logic [POS_W-1:0]     pos_eff;
  logic [SEG_CNT_W-1:0] cnt_eff;
  logic [15:0]          crc_eff;
  logic                 active;
  logic                 emit;
  logic [15:0]          pec;
  logic                 pec_ok;
  logic [OUT_TDATA_W-1:0] result_data;

  // Result register
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   out_fail;
  logic                   out_last;

  // APB register access; writes complete in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SEGMENTS_IN_USE);
  assign prdata    = (paddr[2] == REG_SEGMENTS_IN_USE) ?
                     APB_DATA_W'(segments_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments_in_use <= SEG_CNT_W'(1);
    end else if (cfg_write) begin
      segments_in_use <= pwdata[SEG_CNT_W-1:0];
    end
  end

  // Effective segment count: zero acts as one, large values clamp.
  always_comb begin
    if (segments_in_use == '0) begin
      segs = SEG_CNT_W'(1);
    end else if (segments_in_use > MaxSegs) begin
      segs = MaxSegs;
    end else begin
      segs = segments_in_use;
    end
  end

  // Input handshake: accept whenever the result register is free or draining.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // A frame start restarts the counters and the CRC before the byte is used.
  assign pos_eff = s_axis_tuser[0] ? '0 : byte_position;
  assign cnt_eff = s_axis_tuser[0] ? '0 : segment_count;
  assign crc_eff = s_axis_tuser[0] ? PEC_SEED : crc_remainder;
  assign active  = cnt_eff < segs;
  assign emit    = in_accept && active && (pos_eff == POS_PEC_LOW);

  // PEC check on the final byte of a segment.
  assign pec    = {crc_eff[14:0], 1'b0};
  assign pec_ok = (pec[15:8] == pec_high_byte) && (pec[7:0] == s_axis_tdata);

  // Next frame state for the byte on the input.
  always_comb begin
    byte_position_next = pos_eff;
    segment_count_next = cnt_eff;
    crc_remainder_next = crc_eff;
    if (active) begin
      if (pos_eff < POS_PEC_HIGH) begin
        crc_remainder_next = pec_update(crc_eff, s_axis_tdata);
        byte_position_next = pos_eff + POS_W'(1);
      end else if (pos_eff == POS_PEC_HIGH) begin
        byte_position_next = POS_PEC_LOW;
      end else begin
        segment_count_next = cnt_eff + SEG_CNT_W'(1);
        byte_position_next = '0;
        crc_remainder_next = PEC_SEED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      segment_count <= '0;
      crc_remainder <= PEC_SEED;
    end else if (in_accept) begin
      byte_position <= byte_position_next;
      segment_count <= segment_count_next;
      crc_remainder <= crc_remainder_next;
    end
  end

  // Data byte and PEC high byte capture.
  always_ff @(posedge clk) begin
    if (in_accept && active) begin
      if (pos_eff < POS_PEC_HIGH) begin
        data_bytes[pos_eff] <= s_axis_tdata;
      end else if (pos_eff == POS_PEC_HIGH) begin
        pec_high_byte <= s_axis_tdata;
      end
    end
  end

  // Result packing; failed segments carry zero words.
  always_comb begin
    result_data = '0;
    result_data[SEG_IDX_W-1:0] = cnt_eff[SEG_IDX_W-1:0];
    if (pec_ok) begin
      result_data[OUT_USED_W-1:SEG_IDX_W] = {data_bytes[5], data_bytes[4],
                                             data_bytes[3], data_bytes[2],
                                             data_bytes[1], data_bytes[0]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result_data;
      out_fail <= !pec_ok;
      out_last <= (cnt_eff + SEG_CNT_W'(1)) == segs;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_fail;
  assign m_axis_tlast    = out_last;

endmodule

/* rtl/pec15sfc_checker.sv */
// Port-level assertions for the PEC-15 segment frame checker, bound to the top level.
// Depends on pec15sfc_pkg and pec15_segment_frame_checker_unit.
module pec15sfc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [pec15sfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                           m_axis_tuser
);
  import pec15sfc_pkg::*;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

  // Input is never refused while the result register is empty.
  a_ready_when_empty: assert property (@(posedge clk) !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result register");

  // A checksum failure carries zero register words.
  a_fail_zero_words: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[OUT_USED_W-1:SEG_IDX_W] == '0))
    else $error("failed segment carries non-zero words");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind pec15_segment_frame_checker_unit pec15sfc_checker u_pec15sfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
